// ===== hw/rtl/sahf_pkg.sv =====
// Shared widths, codes and controller/datapath interface types for the speech activity machine.
`timescale 1ns / 1ps

package sahf_pkg;

  localparam int CFG_W     = 18;
  localparam int RATE_W    = 12;
  localparam int FRAME_W   = 10;
  localparam int LEVEL_W   = 17;
  localparam int RATIO_W   = 17;
  localparam int PHASE_W   = 3;
  localparam int DELTA_W   = FRAME_W + RATE_W;
  localparam int DIV_STEPS = RATIO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int REG_IDX_W = 3;

  localparam int TIMER_BITS_DEF = 19;
  localparam int TOTAL_BITS_DEF = 24;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(65536);

  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TRANS  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SPEAK  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SILENT = 3'd3;
  localparam logic [PHASE_W-1:0] PH_VANISH = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_MIN_SPEECH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPEECH_HOLD   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_HOLD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SPEECH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_VANISHING     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE       = 3'd7;

  localparam logic [CFG_W-1:0]  MIN_SPEECH_RST    = CFG_W'(1000);
  localparam logic [CFG_W-1:0]  SPEECH_HOLD_RST   = CFG_W'(5000);
  localparam logic [CFG_W-1:0]  SILENCE_HOLD_RST  = CFG_W'(5000);
  localparam logic [CFG_W-1:0]  MAX_SPEECH_RST    = CFG_W'(60000);
  localparam logic [CFG_W-1:0]  SILENCE_LIMIT_RST = CFG_W'(20000);
  localparam logic [CFG_W-1:0]  VANISHING_RST     = CFG_W'(20000);
  localparam logic [RATE_W-1:0] ATTACK_RST        = RATE_W'(131);
  localparam logic [RATE_W-1:0] RELEASE_RST       = RATE_W'(131);

  typedef struct packed {
    logic [CFG_W-1:0]  min_speech_ms;
    logic [CFG_W-1:0]  speech_hold_ms;
    logic [CFG_W-1:0]  silence_hold_ms;
    logic [CFG_W-1:0]  max_speech_ms;
    logic [CFG_W-1:0]  silence_limit_ms;
    logic [CFG_W-1:0]  vanishing_ms;
    logic [RATE_W-1:0] attack_rate;
    logic [RATE_W-1:0] release_rate;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic time_step;
    logic div_first;
    logic div_step;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/sahf_ctrl.sv =====
// Sequencing controller: accept, timer step, serial ratio divide, state update.
`timescale 1ns / 1ps

module sahf_ctrl import sahf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TIME  = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.load      = in_ready && in_valid;
    cmd.time_step = (state == S_TIME);
    cmd.div_step  = (state == S_DIV);
    cmd.div_first = (state == S_DIV) && (cnt == '0);
    cmd.apply     = (state == S_APPLY) && !stat.out_busy;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_TIME;
      end
      S_TIME: begin
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_APPLY;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_APPLY: begin
        if (cmd.apply) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== hw/rtl/sahf_dp.sv =====
// Datapath: session state, timers, totals, level arithmetic, ratio divider, result register.
`timescale 1ns / 1ps

module sahf_dp import sahf_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  cfg_t               cfg,
  input  logic               voice,
  input  logic               decision_changed,
  input  logic [FRAME_W-1:0] frame_ms,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [PHASE_W-1:0] session_state,
  output logic [LEVEL_W-1:0] smooth_level,
  output logic [RATIO_W-1:0] speaking_ratio,
  output logic               state_entered
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int SUM_W = DELTA_W + 1;
  localparam int DEN_W = TOTAL_BITS + 1;
  localparam int REM_W = TOTAL_BITS + 2;

  logic                  voiced_q;
  logic                  changed_q;
  logic [FRAME_W-1:0]    dt_q;
  logic [PHASE_W-1:0]    phase;
  logic [LEVEL_W-1:0]    level;
  logic [TIMER_BITS-1:0] sdc;
  logic [TIMER_BITS-1:0] ssc;
  logic [TIMER_BITS-1:0] sls;
  logic [TOTAL_BITS-1:0] sp_total;
  logic [TOTAL_BITS-1:0] sil_total;
  logic [DELTA_W-1:0]    delta;
  logic [REM_W-1:0]      div_rem;
  logic [DEN_W-1:0]      div_den;
  logic [RATIO_W-1:0]    quot;

  function automatic logic [TIMER_BITS-1:0] tmr_add(input logic [TIMER_BITS-1:0] a,
                                                    input logic [FRAME_W-1:0] b);
    logic [TIMER_BITS:0] s;
    s = {1'b0, a} + (TIMER_BITS + 1)'(b);
    return s[TIMER_BITS] ? '1 : s[TIMER_BITS-1:0];
  endfunction

  function automatic logic [TOTAL_BITS-1:0] tot_add(input logic [TOTAL_BITS-1:0] a,
                                                    input logic [FRAME_W-1:0] b);
    logic [TOTAL_BITS:0] s;
    s = {1'b0, a} + (TOTAL_BITS + 1)'(b);
    return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
  endfunction

  function automatic logic gt(input logic [TIMER_BITS-1:0] t, input logic [CFG_W-1:0] c);
    return CMP_W'(t) > CMP_W'(c);
  endfunction

  // divider step
  logic [REM_W-1:0] r_sh;
  logic             r_ge;
  always_comb begin
    r_sh = cmd.div_first ? div_rem : {div_rem[REM_W-2:0], 1'b0};
    r_ge = (r_sh >= REM_W'(div_den));
  end

  // level move by the registered delta
  logic [SUM_W-1:0]   up_sum;
  logic [LEVEL_W-1:0] up_lvl;
  logic [LEVEL_W-1:0] dn_lvl;
  logic [LEVEL_W-1:0] moved;
  always_comb begin
    up_sum = SUM_W'(level) + SUM_W'(delta);
    up_lvl = (up_sum > SUM_W'(LEVEL_FULL)) ? LEVEL_FULL : up_sum[LEVEL_W-1:0];
    dn_lvl = (SUM_W'(delta) > SUM_W'(level)) ? '0 : (level - delta[LEVEL_W-1:0]);
    moved  = voiced_q ? up_lvl : dn_lvl;
  end

  logic [PHASE_W-1:0]    phase_next;
  logic [LEVEL_W-1:0]    level_next;
  logic [TIMER_BITS-1:0] ssc_next;
  logic [TIMER_BITS-1:0] sls_next;
  logic [TOTAL_BITS-1:0] sp_next;
  logic [TOTAL_BITS-1:0] sil_next;
  logic                  entered;

  always_comb begin
    phase_next = phase;
    level_next = level;
    ssc_next   = ssc;
    sls_next   = sls;
    sp_next    = sp_total;
    sil_next   = sil_total;
    entered    = 1'b0;
    case (phase)
      PH_IDLE: begin
        sls_next = '0;
        sp_next  = '0;
        sil_next = '0;
        if (voiced_q && gt(sdc, cfg.min_speech_ms)) begin
          phase_next = PH_TRANS;
          entered    = 1'b1;
        end
      end
      PH_TRANS: begin
        level_next = moved;
        if (moved == LEVEL_FULL) begin
          phase_next = PH_SPEAK;
          entered    = 1'b1;
        end
        if (moved == '0) begin
          phase_next = PH_SILENT;
          entered    = 1'b1;
        end
      end
      PH_SPEAK: begin
        sp_next = tot_add(sp_total, dt_q);
        if (gt(ssc, cfg.speech_hold_ms)) level_next = moved;
        if (gt(sls, cfg.max_speech_ms)) begin
          phase_next = PH_VANISH;
          entered    = 1'b1;
        end
        if (level_next < LEVEL_FULL) begin
          phase_next = PH_TRANS;
          entered    = 1'b1;
        end
      end
      PH_SILENT: begin
        sil_next = tot_add(sil_total, dt_q);
        if (gt(ssc, cfg.silence_hold_ms)) level_next = moved;
        if (gt(ssc, cfg.silence_limit_ms)) begin
          phase_next = PH_VANISH;
          entered    = 1'b1;
        end
        if (level_next != '0) begin
          phase_next = PH_TRANS;
          entered    = 1'b1;
        end
      end
      default: begin
        if (gt(ssc, cfg.vanishing_ms)) begin
          phase_next = PH_IDLE;
          entered    = 1'b1;
        end
      end
    endcase
    if (entered) ssc_next = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      voiced_q  <= voice;
      changed_q <= decision_changed;
      dt_q      <= frame_ms;
    end
    if (cmd.time_step) begin
      delta   <= DELTA_W'(dt_q) * DELTA_W'(voiced_q ? cfg.attack_rate : cfg.release_rate);
      div_rem <= REM_W'(sp_total);
      div_den <= DEN_W'(sp_total) + DEN_W'(sil_total);
      quot    <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= r_ge ? (r_sh - REM_W'(div_den)) : r_sh;
      quot    <= {quot[RATIO_W-2:0], r_ge};
    end
    if (cmd.apply) begin
      session_state  <= phase_next;
      smooth_level   <= level_next;
      speaking_ratio <= (div_den == '0) ? '0 : quot;
      state_entered  <= entered;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      level     <= '0;
      sdc       <= '0;
      ssc       <= '0;
      sls       <= '0;
      sp_total  <= '0;
      sil_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.time_step) begin
        sdc <= changed_q ? '0 : tmr_add(sdc, dt_q);
        ssc <= tmr_add(ssc, dt_q);
        sls <= tmr_add(sls, dt_q);
      end
      if (cmd.apply) begin
        phase     <= phase_next;
        level     <= level_next;
        ssc       <= ssc_next;
        sls       <= sls_next;
        sp_total  <= sp_next;
        sil_total <= sil_next;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ===== hw/rtl/speech_activity_hangover_fsm.sv =====
// Top level of the speech activity session machine: stream ports, register port, core.
//
// channel  | direction | handshake                     | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | voice, decision_changed, frame_ms
// m_axis   | out       | m_axis_tvalid / m_axis_tready | state, level, ratio, entered flag
// apb      | in        | psel, penable, pwrite, pready | eight registers at 4*i
//
// An item passes through accept, timer step, 17 steps of the restoring
// ratio divider, and state update, in that order.
// Reset (rst, synchronous) returns to idle with zero level, timers and totals.
// A waiting result holds the update step; the next item is taken once the
// result register has been written.
`timescale 1ns / 1ps

module speech_activity_hangover_fsm import sahf_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] voice, [1] decision_changed, [11:2] frame_ms
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] session_state, [19:3] smooth_level, [36:20] speaking_ratio, [37] state_entered
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t               cfg;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [PHASE_W-1:0] session_state;
  logic [LEVEL_W-1:0] smooth_level;
  logic [RATIO_W-1:0] speaking_ratio;
  logic               state_entered;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_speech_ms    <= MIN_SPEECH_RST;
      cfg.speech_hold_ms   <= SPEECH_HOLD_RST;
      cfg.silence_hold_ms  <= SILENCE_HOLD_RST;
      cfg.max_speech_ms    <= MAX_SPEECH_RST;
      cfg.silence_limit_ms <= SILENCE_LIMIT_RST;
      cfg.vanishing_ms     <= VANISHING_RST;
      cfg.attack_rate      <= ATTACK_RST;
      cfg.release_rate     <= RELEASE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_MIN_SPEECH:    cfg.min_speech_ms    <= pwdata[CFG_W-1:0];
        REG_SPEECH_HOLD:   cfg.speech_hold_ms   <= pwdata[CFG_W-1:0];
        REG_SILENCE_HOLD:  cfg.silence_hold_ms  <= pwdata[CFG_W-1:0];
        REG_MAX_SPEECH:    cfg.max_speech_ms    <= pwdata[CFG_W-1:0];
        REG_SILENCE_LIMIT: cfg.silence_limit_ms <= pwdata[CFG_W-1:0];
        REG_VANISHING:     cfg.vanishing_ms     <= pwdata[CFG_W-1:0];
        REG_ATTACK:        cfg.attack_rate      <= pwdata[RATE_W-1:0];
        REG_RELEASE:       cfg.release_rate     <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_SPEECH:    prdata = 32'(cfg.min_speech_ms);
      REG_SPEECH_HOLD:   prdata = 32'(cfg.speech_hold_ms);
      REG_SILENCE_HOLD:  prdata = 32'(cfg.silence_hold_ms);
      REG_MAX_SPEECH:    prdata = 32'(cfg.max_speech_ms);
      REG_SILENCE_LIMIT: prdata = 32'(cfg.silence_limit_ms);
      REG_VANISHING:     prdata = 32'(cfg.vanishing_ms);
      REG_ATTACK:        prdata = 32'(cfg.attack_rate);
      REG_RELEASE:       prdata = 32'(cfg.release_rate);
      default:           prdata = '0;
    endcase
  end

  sahf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sahf_dp #(
    .TIMER_BITS (TIMER_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg              (cfg),
    .voice            (s_axis_tdata[0]),
    .decision_changed (s_axis_tdata[1]),
    .frame_ms         (s_axis_tdata[11:2]),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .session_state    (session_state),
    .smooth_level     (smooth_level),
    .speaking_ratio   (speaking_ratio),
    .state_entered    (state_entered)
  );

  assign m_axis_tdata = {2'b00, state_entered, speaking_ratio, smooth_level, session_state};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[19:3] <= LEVEL_FULL)
    else $error("smooth level above full scale");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[36:20] <= LEVEL_FULL)
    else $error("speaking ratio above one");
`endif

endmodule
